@@ design/tkpf_pkg.sv @@
// Shared types, constants and helpers for the two-key Playfair digraph cipher.
// No dependencies; every other design file imports this package.
package tkpf_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] pos_t;
    typedef logic [2:0] action_t;

    localparam action_t ACT_CLEAR  = 3'd0;
    localparam action_t ACT_ROW    = 3'd1;
    localparam action_t ACT_COL    = 3'd2;
    localparam action_t ACT_FINISH = 3'd3;
    localparam action_t ACT_PAIR   = 3'd4;

    // Cell coordinates that the selection lanes must drive out
    typedef struct packed {
        pos_t row_a;
        pos_t col_a;
        pos_t row_b;
        pos_t col_b;
    } target_t;

    // What one cell lane reports
    typedef struct packed {
        logic    hit_a;
        logic    hit_b;
        letter_t pick_a;
        letter_t pick_b;
    } lane_out_t;

    // What the merging stage hands back to the top level
    typedef struct packed {
        logic    found_a;
        logic    found_b;
        pos_t    row_a;
        pos_t    col_a;
        pos_t    row_b;
        pos_t    col_b;
        letter_t letter_a;
        letter_t letter_b;
    } merge_out_t;

    // Move one place along a row or column, wrapping at the edge
    function automatic pos_t shift_pos(input pos_t v, input logic backwards);
        pos_t r;
        if (backwards)
            r = (v == 3'd0) ? pos_t'(SIDE - 1) : v - 3'd1;
        else
            r = (v == pos_t'(SIDE - 1)) ? 3'd0 : v + 3'd1;
        return r;
    endfunction

endpackage

@@ design/tkpf_lane.sv @@
// One cell lane: matches the cell's letter against the request letters and
// drives the letter out when the cell is a selected target. Uses tkpf_pkg.
module tkpf_lane (
    input  tkpf_pkg::letter_t   cell_letter,
    input  logic                cell_filled,
    input  tkpf_pkg::pos_t      row_id,
    input  tkpf_pkg::pos_t      col_id,
    input  tkpf_pkg::letter_t   probe_a,
    input  tkpf_pkg::letter_t   probe_b,
    input  tkpf_pkg::target_t   tgt,
    output tkpf_pkg::lane_out_t lane_out
);
    import tkpf_pkg::*;

    always_comb
    begin
        lane_out.hit_a  = cell_filled && (cell_letter == probe_a);
        lane_out.hit_b  = cell_filled && (cell_letter == probe_b);
        lane_out.pick_a = (row_id == tgt.row_a && col_id == tgt.col_a) ? cell_letter : '0;
        lane_out.pick_b = (row_id == tgt.row_b && col_id == tgt.col_b) ? cell_letter : '0;
    end

endmodule

@@ design/tkpf_merge.sv @@
// Merging stage: folds the one-hot lane reports into coordinates and letters.
// Uses tkpf_pkg.
module tkpf_merge (
    input  tkpf_pkg::lane_out_t  lane_out [tkpf_pkg::CELLS],
    output tkpf_pkg::merge_out_t merged
);
    import tkpf_pkg::*;

    always_comb
    begin
        merged = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            if (lane_out[i].hit_a)
            begin
                merged.found_a = 1'b1;
                merged.row_a   = merged.row_a | pos_t'(i / SIDE);
                merged.col_a   = merged.col_a | pos_t'(i % SIDE);
            end
            if (lane_out[i].hit_b)
            begin
                merged.found_b = 1'b1;
                merged.row_b   = merged.row_b | pos_t'(i / SIDE);
                merged.col_b   = merged.col_b | pos_t'(i % SIDE);
            end
            merged.letter_a = merged.letter_a | lane_out[i].pick_a;
            merged.letter_b = merged.letter_b | lane_out[i].pick_b;
        end
    end

endmodule

@@ design/two_key_playfair_digraph_cipher.sv @@
// Top level of the two-key Playfair digraph cipher: square store, fill logic,
// request sequencer and output register. Uses tkpf_pkg, tkpf_lane, tkpf_merge.
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ---------------------------------
//  in        sink       in_valid / in_ready  action, letter_first, letter_second
//  out       source     out_valid/out_ready  out_first, out_second, error
//  cfg       sink       cfg_valid/cfg_ready  decrypt_mode
//
// Clear, row and column keyword requests complete in the cycle they are
// accepted. For a pair, the 25 cell lanes locate both letters at acceptance;
// then, in ST_PICK, the coordinates are shifted and the letters are read
// back through the same lanes into the output register. A finish request
// walks the 25 cells one per cycle, holding in_ready low until the last cell.
// Reset clears the square, fill pointers and mode at once; no clearing pass.
// A stalled output holds the pair in ST_PICK; in_ready stays low until the
// result moves into the output register. cfg_ready is always high.
module two_key_playfair_digraph_cipher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tkpf_pkg::action_t action,
    input  tkpf_pkg::letter_t letter_first,
    input  tkpf_pkg::letter_t letter_second,
    output logic              out_valid,
    input  logic              out_ready,
    output tkpf_pkg::letter_t out_first,
    output tkpf_pkg::letter_t out_second,
    output logic              error,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              decrypt_mode
);
    import tkpf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FINISH,
        ST_PICK
    } state_t;

    // Square store: one letter per cell, gated by its filled bit
    letter_t            square_reg [CELLS];
    logic [CELLS-1:0]   filled_reg, filled_next;
    logic [LETTERS-1:0] used_reg, used_next;
    logic [4:0]         row_idx_reg, row_idx_next;
    logic [4:0]         col_idx_reg, col_idx_next;
    logic [4:0]         fin_cell_reg, fin_cell_next;
    logic               complete_reg, complete_next;
    logic               decrypt_reg;
    state_t             state_reg, state_next;

    // Located pair, held from acceptance of a pair request through ST_PICK
    target_t            hit_reg, hit_next;
    logic               err_reg, err_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    letter_t            out_first_reg, out_first_next;
    letter_t            out_second_reg, out_second_next;
    logic               error_reg, error_next;

    // Placement of one letter this cycle
    logic [CELLS-1:0]   place_mask;
    letter_t            place_letter;
    logic               place_en;

    // Empty-cell searches
    logic [CELLS-1:0]   row_avail, row_iso;
    logic [CELLS-1:0]   col_avail, col_iso, col_cells;
    logic [4:0]         row_pos, col_pos;
    logic [LETTERS-1:0] unused, unused_iso;
    letter_t            unused_pos;
    logic               key_ok;
    logic               slot_free;

    target_t            tgt;
    lane_out_t          lane_out [CELLS];
    merge_out_t         merged;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign error      = error_reg;
    assign slot_free  = !out_valid_reg || out_ready;

    // Cell lanes: match at acceptance, select in ST_PICK
    for (genvar g = 0; g < CELLS; g++)
    begin : g_lane
        localparam pos_t ROW_ID = pos_t'(g / SIDE);
        localparam pos_t COL_ID = pos_t'(g % SIDE);

        tkpf_lane u_lane (
            .cell_letter (square_reg[g]),
            .cell_filled (filled_reg[g]),
            .row_id      (ROW_ID),
            .col_id      (COL_ID),
            .probe_a     (letter_first),
            .probe_b     (letter_second),
            .tgt         (tgt),
            .lane_out    (lane_out[g])
        );
    end

    tkpf_merge u_merge (
        .lane_out (lane_out),
        .merged   (merged)
    );

    // Playfair rules on the held coordinates
    always_comb
    begin
        tgt = hit_reg;
        if (hit_reg.row_a == hit_reg.row_b)
        begin
            tgt.col_a = shift_pos(hit_reg.col_a, decrypt_reg);
            tgt.col_b = shift_pos(hit_reg.col_b, decrypt_reg);
        end
        else if (hit_reg.col_a == hit_reg.col_b)
        begin
            tgt.row_a = shift_pos(hit_reg.row_a, decrypt_reg);
            tgt.row_b = shift_pos(hit_reg.row_b, decrypt_reg);
        end
        else
        begin
            // rectangle: swap the columns
            tgt.col_a = hit_reg.col_b;
            tgt.col_b = hit_reg.col_a;
        end
    end

    // First empty cell in row order and in column order, from the fill pointers
    always_comb
    begin
        col_cells = '0;
        row_pos   = '0;
        col_pos   = '0;
        for (int p = 0; p < CELLS; p++)
        begin
            row_avail[p] = !filled_reg[p] && (5'(p) >= row_idx_reg);
            col_avail[p] = !filled_reg[(p % SIDE) * SIDE + p / SIDE] && (5'(p) >= col_idx_reg);
        end
        row_iso = row_avail & (~row_avail + CELLS'(1));
        col_iso = col_avail & (~col_avail + CELLS'(1));
        for (int p = 0; p < CELLS; p++)
        begin
            if (row_iso[p])
                row_pos = row_pos | 5'(p);
            if (col_iso[p])
                col_pos = col_pos | 5'(p);
            col_cells[(p % SIDE) * SIDE + p / SIDE] = col_iso[p];
        end
    end

    // Lowest letter not yet in the square, for the finish sweep
    always_comb
    begin
        unused     = ~used_reg;
        unused_iso = unused & (~unused + LETTERS'(1));
        unused_pos = '0;
        for (int l = 0; l < LETTERS; l++)
        begin
            if (unused_iso[l])
                unused_pos = unused_pos | letter_t'(l);
        end
    end

    assign key_ok = (letter_first < letter_t'(LETTERS)) && !used_reg[letter_first];

    always_comb
    begin
        state_next      = state_reg;
        filled_next     = filled_reg;
        used_next       = used_reg;
        row_idx_next    = row_idx_reg;
        col_idx_next    = col_idx_reg;
        fin_cell_next   = fin_cell_reg;
        complete_next   = complete_reg;
        hit_next        = hit_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        error_next      = error_reg;
        place_mask      = '0;
        place_letter    = letter_first;
        place_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        ACT_CLEAR:
                        begin
                            filled_next   = '0;
                            used_next     = '0;
                            row_idx_next  = '0;
                            col_idx_next  = '0;
                            complete_next = 1'b0;
                        end
                        ACT_ROW:
                        begin
                            if (key_ok)
                            begin
                                if (|row_avail)
                                begin
                                    place_mask   = row_iso;
                                    place_en     = 1'b1;
                                    row_idx_next = row_pos + 5'd1;
                                end
                                else
                                    row_idx_next = 5'(CELLS);
                            end
                        end
                        ACT_COL:
                        begin
                            if (key_ok)
                            begin
                                if (|col_avail)
                                begin
                                    place_mask   = col_cells;
                                    place_en     = 1'b1;
                                    col_idx_next = col_pos + 5'd1;
                                end
                                else
                                    col_idx_next = 5'(CELLS);
                            end
                        end
                        ACT_FINISH:
                        begin
                            fin_cell_next = '0;
                            state_next    = ST_FINISH;
                        end
                        ACT_PAIR:
                        begin
                            hit_next.row_a = merged.row_a;
                            hit_next.col_a = merged.col_a;
                            hit_next.row_b = merged.row_b;
                            hit_next.col_b = merged.col_b;
                            err_next   = !complete_reg || !merged.found_a || !merged.found_b;
                            state_next = ST_PICK;
                        end
                        default:
                        begin
                            // unused action codes: drop the request
                        end
                    endcase
                end
            end

            ST_FINISH:
            begin
                // fill empty cells in row order with the lowest unused letters
                if (!filled_reg[fin_cell_reg] && (|unused))
                begin
                    place_mask   = CELLS'(1) << fin_cell_reg;
                    place_letter = unused_pos;
                    place_en     = 1'b1;
                end
                if (fin_cell_reg == 5'(CELLS - 1))
                begin
                    row_idx_next  = 5'(CELLS);
                    col_idx_next  = 5'(CELLS);
                    complete_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                    fin_cell_next = fin_cell_reg + 5'd1;
            end

            ST_PICK:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_first_next  = err_reg ? '0 : merged.letter_a;
                    out_second_next = err_reg ? '0 : merged.letter_b;
                    error_next      = err_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        filled_next = filled_next | place_mask;
        if (place_en)
            used_next[place_letter] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filled_reg    <= '0;
            used_reg      <= '0;
            row_idx_reg   <= '0;
            col_idx_reg   <= '0;
            fin_cell_reg  <= '0;
            complete_reg  <= 1'b0;
            decrypt_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            filled_reg     <= filled_next;
            used_reg       <= used_next;
            row_idx_reg    <= row_idx_next;
            col_idx_reg    <= col_idx_next;
            fin_cell_reg   <= fin_cell_next;
            complete_reg   <= complete_next;
            out_valid_reg  <= out_valid_next;
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            error_reg      <= error_next;
            hit_reg        <= hit_next;
            err_reg        <= err_next;
            if (cfg_valid)
                decrypt_reg <= decrypt_mode;
        end
    end

    // Cell letters carry no reset: an empty cell is masked by its filled bit
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < CELLS; c++)
        begin
            if (place_mask[c])
                square_reg[c] <= place_letter;
        end
    end

endmodule
